[rtl/lssc_pkg.sv]
package lssc_pkg;

    localparam int REF_W    = 20;
    localparam int CONF_W   = 3;
    localparam int LAT_W    = 16;
    localparam int LOSS_W   = 15;
    localparam int JIT_W    = 16;
    localparam int THR_W    = 24;
    localparam int STAGE_W  = 3;
    localparam int STRESS_W = 7;
    localparam int SCORE_W  = 14;
    localparam int SUM_W    = 20;
    localparam int NUM_W    = 34;
    localparam int QUO_W    = 14;
    localparam int STEP_W   = 4;

    typedef enum logic [1:0] {
        FUNC_LAT_OBS = 2'd0,
        FUNC_DIRECT  = 2'd1,
        FUNC_THR     = 2'd2,
        FUNC_TICK    = 2'd3
    } t_func;

    localparam logic CFG_REF     = 1'b0;
    localparam logic CFG_CONFIRM = 1'b1;

    localparam logic [SCORE_W-1:0]  SCORE_MAX  = 14'd10000;
    localparam logic [LAT_W-1:0]    LAT_SAT    = 16'd1000;
    localparam logic [JIT_W-1:0]    JIT_SAT    = 16'd200;
    localparam logic [LAT_W-1:0]    LOSS_TH_HI = 16'd800;
    localparam logic [LAT_W-1:0]    LOSS_TH_MD = 16'd400;
    localparam logic [LAT_W-1:0]    LOSS_TH_LO = 16'd150;
    localparam logic [LOSS_W-1:0]   LOSS_EST_HI = 15'sd6000;
    localparam logic [LOSS_W-1:0]   LOSS_EST_MD = 15'sd3000;
    localparam logic [LOSS_W-1:0]   LOSS_EST_LO = 15'sd1000;
    // 2^34 / 10000 rounded up, exact for sums below 2^20
    localparam logic [20:0]         RECIP_10K  = 21'd1717987;
    localparam int                  RECIP_SH   = 34;

    localparam logic [STAGE_W-1:0]  STAGE_1 = 3'd1;
    localparam logic [STAGE_W-1:0]  STAGE_2 = 3'd2;
    localparam logic [STAGE_W-1:0]  STAGE_3 = 3'd3;
    localparam logic [STAGE_W-1:0]  STAGE_4 = 3'd4;
    localparam logic [STAGE_W-1:0]  STAGE_5 = 3'd5;
    localparam logic [STAGE_W-1:0]  STAGE_6 = 3'd6;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_MUL   = 7'b0000010,
        S_DINIT = 7'b0000100,
        S_DIV   = 7'b0001000,
        S_SUM   = 7'b0010000,
        S_SCALE = 7'b0100000,
        S_OUT   = 7'b1000000
    } t_state;

    typedef struct packed {
        logic accept;
        logic mul;
        logic div_init;
        logic div_step;
        logic sum;
        logic scale;
        logic out_load;
        logic out_tick;
    } t_cmd;

    function automatic logic [STAGE_W-1:0] stage_of(input logic [STRESS_W-1:0] s);
        logic [STAGE_W-1:0] st;
        if (s >= 7'd80)      st = STAGE_6;
        else if (s >= 7'd60) st = STAGE_5;
        else if (s >= 7'd40) st = STAGE_4;
        else if (s >= 7'd25) st = STAGE_3;
        else if (s >= 7'd12) st = STAGE_2;
        else                 st = STAGE_1;
        return st;
    endfunction

endpackage

[rtl/lssc_ctrl.sv]
module lssc_ctrl import lssc_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_in_valid,
    input  logic [1:0]   i_func,
    input  logic         i_out_stall,
    output logic         o_in_stall,
    output logic         o_out_valid,
    output t_cmd         o_cmd
);

    t_state              r_state, n_state;
    logic [STEP_W-1:0]   r_cnt, n_cnt;
    logic                r_out_valid, n_out_valid;
    logic                out_free;
    logic                accept;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE) || (r_out_valid && i_out_stall);
    assign accept     = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.accept = 1'b1;
                    if (t_func'(i_func) == FUNC_TICK) begin
                        n_state = S_MUL;
                    end else begin
                        o_cmd.out_load = 1'b1;
                    end
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_DINIT;
            end
            S_DINIT: begin
                o_cmd.div_init = 1'b1;
                n_cnt          = '0;
                n_state        = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == STEP_W'(QUO_W - 1)) begin
                    n_state = S_SUM;
                end
            end
            S_SUM: begin
                o_cmd.sum = 1'b1;
                n_state   = S_SCALE;
            end
            S_SCALE: begin
                o_cmd.scale = 1'b1;
                n_state     = S_OUT;
            end
            S_OUT: begin
                // stage filter and result load share this cycle
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_tick = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

[rtl/lssc_dp.sv]
module lssc_dp import lssc_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cmd                 i_cmd,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_index,
    input  logic [REF_W-1:0]     i_cfg_data,
    input  logic [1:0]           i_func,
    input  logic [LAT_W-1:0]     i_latency_ms,
    input  logic [LOSS_W-1:0]    i_loss_hundredths,
    input  logic [JIT_W-1:0]     i_jitter_ms,
    input  logic [THR_W-1:0]     i_throughput_bps,
    output logic [STAGE_W-1:0]   o_stage,
    output logic [STRESS_W-1:0]  o_stress,
    output logic                 o_stage_changed
);

    logic [REF_W-1:0]     r_ref;
    logic [CONF_W-1:0]    r_confirm;
    logic [LAT_W-1:0]     r_lat, r_prev;
    logic [LOSS_W-1:0]    r_loss;
    logic [JIT_W-1:0]     r_jit;
    logic [THR_W-1:0]     r_thr;
    logic [STRESS_W-1:0]  r_stress;
    logic [STAGE_W-1:0]   r_conf, r_cand;
    logic [CONF_W-1:0]    r_agree;
    logic [NUM_W-1:0]     r_num;
    logic [REF_W-1:0]     r_rem;
    logic [QUO_W-1:0]     r_low;
    logic [QUO_W-1:0]     r_quo;
    logic [SUM_W-1:0]     r_sum;
    logic [STAGE_W-1:0]   r_o_stage;
    logic [STRESS_W-1:0]  r_o_stress;
    logic                 r_o_changed;

    logic [LAT_W-1:0]     lat_step;
    logic [LOSS_W-1:0]    est_loss;
    logic [REF_W-1:0]     tp_diff;
    logic [REF_W:0]       trial;
    logic                 trial_ge;
    logic [SCORE_W-1:0]   lat_s, loss_s, jit_s, tp_s;
    logic [SUM_W-1:0]     sum_v;
    logic [40:0]          scaled;
    logic [STAGE_W-1:0]   target;
    logic [STAGE_W-1:0]   n_conf, n_cand;
    logic [CONF_W-1:0]    n_agree;
    logic                 n_changed;

    // latency observation
    assign lat_step = (i_latency_ms >= r_prev) ? (i_latency_ms - r_prev)
                                               : (r_prev - i_latency_ms);
    always_comb begin
        if (i_latency_ms > LOSS_TH_HI)      est_loss = LOSS_EST_HI;
        else if (i_latency_ms > LOSS_TH_MD) est_loss = LOSS_EST_MD;
        else if (i_latency_ms > LOSS_TH_LO) est_loss = LOSS_EST_LO;
        else                                est_loss = '0;
    end

    // restoring divider, one quotient bit per step
    assign tp_diff  = r_ref - r_thr[REF_W-1:0];
    assign trial    = {r_rem, r_low[QUO_W-1]};
    assign trial_ge = trial >= {1'b0, r_ref};

    // clamped scores in hundredths
    always_comb begin
        lat_s = (r_lat > LAT_SAT) ? SCORE_MAX : SCORE_W'(r_lat * 16'd10);
        jit_s = (r_jit > JIT_SAT) ? SCORE_MAX : SCORE_W'(r_jit * 16'd50);
        if (r_loss[LOSS_W-1])
            loss_s = '0;
        else if (r_loss[LOSS_W-2:0] > SCORE_MAX)
            loss_s = SCORE_MAX;
        else
            loss_s = r_loss[LOSS_W-2:0];
        if (r_thr == '0)
            tp_s = SCORE_MAX;
        else if (r_thr >= {{(THR_W-REF_W){1'b0}}, r_ref})
            tp_s = '0;
        else
            tp_s = r_quo;
    end

    assign sum_v = SUM_W'(lat_s) * 20'd35 + SUM_W'(loss_s) * 20'd35
                 + SUM_W'(jit_s) * 20'd10 + SUM_W'(tp_s) * 20'd20;

    assign scaled = 41'(r_sum) * 41'(RECIP_10K);

    // stage filter
    assign target = stage_of(r_stress);
    always_comb begin
        n_conf    = r_conf;
        n_cand    = r_cand;
        n_agree   = r_agree;
        n_changed = 1'b0;
        if (target != r_conf) begin
            if (target == r_cand) begin
                if (r_agree != 3'd7) n_agree = r_agree + 1'b1;
            end else begin
                n_cand  = target;
                n_agree = 3'd1;
            end
            if (n_agree >= r_confirm) begin
                n_conf    = target;
                n_agree   = '0;
                n_changed = 1'b1;
            end
        end else begin
            n_agree = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref     <= 20'd600;
            r_confirm <= 3'd2;
            r_lat     <= '0;
            r_prev    <= '0;
            r_loss    <= '0;
            r_jit     <= '0;
            r_thr     <= '0;
            r_stress  <= '0;
            r_conf    <= STAGE_1;
            r_cand    <= STAGE_1;
            r_agree   <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_REF:     r_ref     <= i_cfg_data;
                    CFG_CONFIRM: r_confirm <= i_cfg_data[CONF_W-1:0];
                    default:     ;
                endcase
            end
            if (i_cmd.accept) begin
                case (t_func'(i_func))
                    FUNC_LAT_OBS: begin
                        r_lat  <= i_latency_ms;
                        r_prev <= i_latency_ms;
                        r_loss <= est_loss;
                        r_jit  <= lat_step;
                    end
                    FUNC_DIRECT: begin
                        r_lat  <= i_latency_ms;
                        r_loss <= i_loss_hundredths;
                        r_jit  <= i_jitter_ms;
                    end
                    FUNC_THR: begin
                        r_thr <= i_throughput_bps;
                    end
                    default: ;
                endcase
            end
            if (i_cmd.scale) begin
                r_stress <= scaled[RECIP_SH +: STRESS_W];
            end
            if (i_cmd.out_load && i_cmd.out_tick) begin
                r_conf  <= n_conf;
                r_cand  <= n_cand;
                r_agree <= n_agree;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_num <= NUM_W'(tp_diff) * NUM_W'(SCORE_MAX);
        end
        if (i_cmd.div_init) begin
            // quotient stays below 2^14, so the top part is already below the divisor
            r_rem <= r_num[NUM_W-1:QUO_W];
            r_low <= r_num[QUO_W-1:0];
            r_quo <= '0;
        end else if (i_cmd.div_step) begin
            r_rem <= trial_ge ? REF_W'(trial - {1'b0, r_ref}) : trial[REF_W-1:0];
            r_low <= {r_low[QUO_W-2:0], 1'b0};
            r_quo <= {r_quo[QUO_W-2:0], trial_ge};
        end
        if (i_cmd.sum) begin
            r_sum <= sum_v;
        end
        if (i_cmd.out_load) begin
            r_o_stage   <= i_cmd.out_tick ? n_conf : r_conf;
            r_o_stress  <= r_stress;
            r_o_changed <= i_cmd.out_tick & n_changed;
        end
    end

    assign o_stage         = r_o_stage;
    assign o_stress        = r_o_stress;
    assign o_stage_changed = r_o_changed;

endmodule

[rtl/link_stress_stage_classifier_unit.sv]
// Link stress stage classifier. Each transfer on the input channel is a latency
// observation, a direct metrics update, a throughput update or an evaluation tick,
// and each one yields exactly one result transfer carrying the confirmed stage
// (1 to 6), the last stress index (0 to 100) and a flag set when a tick confirmed a
// new stage. A metric update loads its result in the cycle it is accepted. For a tick,
// the throughput score comes from a restoring divider that resolves one quotient bit
// per cycle, followed by the weighted sum, the scaling to 0..100 and the stage
// filter. The unit handles one item at a time, and a result held by output stall
// also holds off the next input until that result has gone.
// Register 0 is the reference throughput, register 1 the number of agreeing ticks
// needed; write them only while the unit is idle.
module link_stress_stage_classifier_unit import lssc_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_index,
    input  logic [REF_W-1:0]     i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [1:0]           i_func,
    input  logic [LAT_W-1:0]     i_latency_ms,
    input  logic [LOSS_W-1:0]    i_loss_hundredths,
    input  logic [JIT_W-1:0]     i_jitter_ms,
    input  logic [THR_W-1:0]     i_throughput_bps,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [STAGE_W-1:0]   o_stage,
    output logic [STRESS_W-1:0]  o_stress,
    output logic                 o_stage_changed
);

    t_cmd cmd;

    lssc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_func      (i_func),
        .i_out_stall (i_out_stall),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd)
    );

    lssc_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_func            (i_func),
        .i_latency_ms      (i_latency_ms),
        .i_loss_hundredths (i_loss_hundredths),
        .i_jitter_ms       (i_jitter_ms),
        .i_throughput_bps  (i_throughput_bps),
        .o_stage           (o_stage),
        .o_stress          (o_stress),
        .o_stage_changed   (o_stage_changed)
    );

endmodule

[dv/tb.sv]
`timescale 1ns / 1ps

module tb;
    import lssc_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 40;

    typedef struct packed {
        logic [STAGE_W-1:0]  stage;
        logic [STRESS_W-1:0] stress;
        logic                changed;
    } t_grade;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_cfg_we = 1'b0;
    logic                i_cfg_index = CFG_REF;
    logic [REF_W-1:0]    i_cfg_data = '0;
    logic                i_in_valid = 1'b0;
    logic                o_in_stall;
    logic [1:0]          i_func = FUNC_LAT_OBS;
    logic [LAT_W-1:0]    i_latency_ms = '0;
    logic [LOSS_W-1:0]   i_loss_hundredths = '0;
    logic [JIT_W-1:0]    i_jitter_ms = '0;
    logic [THR_W-1:0]    i_throughput_bps = '0;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    logic [STAGE_W-1:0]  o_stage;
    logic [STRESS_W-1:0] o_stress;
    logic                o_stage_changed;

    link_stress_stage_classifier_unit i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_func            (i_func),
        .i_latency_ms      (i_latency_ms),
        .i_loss_hundredths (i_loss_hundredths),
        .i_jitter_ms       (i_jitter_ms),
        .i_throughput_bps  (i_throughput_bps),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_stage           (o_stage),
        .o_stress          (o_stress),
        .o_stage_changed   (o_stage_changed)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // predicted link metrics and stage filter
    logic [REF_W-1:0]         ref_bps;
    logic [CONF_W-1:0]        confirm_need;
    logic [LAT_W-1:0]         lat_now;
    logic [LAT_W-1:0]         lat_prev;
    logic signed [LOSS_W-1:0] loss_now;
    logic [JIT_W-1:0]         jit_now;
    logic [THR_W-1:0]         thr_now;
    logic [STRESS_W-1:0]      stress_now;
    logic [STAGE_W-1:0]       stage_now;
    logic [STAGE_W-1:0]       stage_cand;
    logic [CONF_W-1:0]        agree_cnt;

    t_grade expected_grades[$];
    int     fail_count = 0;
    int     idle_pct = 28;
    int     stalled_cycles = 0;

    function automatic longint cap_score(input longint v);
        return (v > 10000) ? 10000 : v;
    endfunction

    function automatic logic [STAGE_W-1:0] stage_for_stress(input logic [STRESS_W-1:0] s);
        logic [STAGE_W-1:0] st;
        if (s >= 80)      st = STAGE_6;
        else if (s >= 60) st = STAGE_5;
        else if (s >= 40) st = STAGE_4;
        else if (s >= 25) st = STAGE_3;
        else if (s >= 12) st = STAGE_2;
        else              st = STAGE_1;
        return st;
    endfunction

    function automatic void predict_grade(input t_func f, input logic [LAT_W-1:0] lat,
                                          input logic [LOSS_W-1:0] loss,
                                          input logic [JIT_W-1:0] jit,
                                          input logic [THR_W-1:0] thr);
        longint             lat_s;
        longint             loss_s;
        longint             jit_s;
        longint             tp_s;
        longint             total;
        logic [STAGE_W-1:0] target;
        t_grade             g;
        g.changed = 1'b0;
        case (f)
            FUNC_LAT_OBS: begin
                jit_now  = (lat >= lat_prev) ? lat - lat_prev : lat_prev - lat;
                lat_prev = lat;
                lat_now  = lat;
                // loss estimated from latency bands
                if (lat > 800)      loss_now = 15'sd6000;
                else if (lat > 400) loss_now = 15'sd3000;
                else if (lat > 150) loss_now = 15'sd1000;
                else                loss_now = 15'sd0;
            end
            FUNC_DIRECT: begin
                lat_now  = lat;
                loss_now = loss;
                jit_now  = jit;
            end
            FUNC_THR: begin
                thr_now = thr;
            end
            default: begin
                lat_s  = cap_score(longint'(lat_now) * 10);
                jit_s  = cap_score(longint'(jit_now) * 50);
                loss_s = (loss_now < 0) ? 0 : cap_score(longint'(loss_now));
                if (thr_now == 0)
                    tp_s = 10000;
                else if (thr_now >= ref_bps)
                    tp_s = 0;
                else
                    tp_s = cap_score((longint'(ref_bps) - longint'(thr_now)) * 10000
                                     / longint'(ref_bps));
                total = (35 * lat_s + 35 * loss_s + 10 * jit_s + 20 * tp_s) / 10000;
                stress_now = (total > 100) ? 7'd100 : total[STRESS_W-1:0];
                target = stage_for_stress(stress_now);
                if (target != stage_now) begin
                    if (target == stage_cand) begin
                        if (agree_cnt < 7) agree_cnt = agree_cnt + 1'b1;
                    end else begin
                        stage_cand = target;
                        agree_cnt  = 3'd1;
                    end
                    if (agree_cnt >= confirm_need) begin
                        stage_now = target;
                        agree_cnt = '0;
                        g.changed = 1'b1;
                    end
                end else begin
                    agree_cnt = '0;
                end
            end
        endcase
        g.stage  = stage_now;
        g.stress = stress_now;
        expected_grades.push_back(g);
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        fail_count++;
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    endtask

    always @(posedge i_clk) begin
        t_grade want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_grades.size() == 0) begin
                report_mismatch("unexpected result, stage", int'(o_stage), 0);
            end else begin
                want = expected_grades.pop_front();
                if (o_stage !== want.stage)
                    report_mismatch("stage", int'(o_stage), int'(want.stage));
                if (o_stress !== want.stress)
                    report_mismatch("stress", int'(o_stress), int'(want.stress));
                if (o_stage_changed !== want.changed)
                    report_mismatch("stage_changed", int'(o_stage_changed),
                                    int'(want.changed));
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n)
            i_out_stall <= 1'b0;
        else
            i_out_stall <= (idle_pct != 0) && ($urandom_range(0, 99) < idle_pct);
    end

    // watchdog on cycles with no transfer and no register write
    always @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we || (i_in_valid && !o_in_stall) ||
            (o_out_valid && !i_out_stall)) begin
            stalled_cycles <= 0;
        end else begin
            stalled_cycles <= stalled_cycles + 1;
            if (stalled_cycles >= WATCHDOG_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    // returns at the edge where the transfer happened, valid left high
    task automatic send_item(input t_func f, input logic [LAT_W-1:0] lat,
                             input logic [LOSS_W-1:0] loss, input logic [JIT_W-1:0] jit,
                             input logic [THR_W-1:0] thr);
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_in_valid        <= 1'b1;
        i_func            <= f;
        i_latency_ms      <= lat;
        i_loss_hundredths <= loss;
        i_jitter_ms       <= jit;
        i_throughput_bps  <= thr;
        do @(posedge i_clk); while (o_in_stall);
        predict_grade(f, lat, loss, jit, thr);
    endtask

    task automatic send_tick();
        send_item(FUNC_TICK, LAT_W'($urandom), LOSS_W'($urandom), JIT_W'($urandom),
                  THR_W'($urandom));
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (expected_grades.size() != 0) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic idx, input logic [REF_W-1:0] data);
        drain_results();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        if (idx == CFG_REF) ref_bps = data;
        else                confirm_need = data[CONF_W-1:0];
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_random_update(input t_func f);
        logic [LAT_W-1:0]  lat;
        logic [LOSS_W-1:0] loss;
        logic [JIT_W-1:0]  jit;
        logic [THR_W-1:0]  thr;
        lat  = ($urandom_range(0, 9) < 8) ? LAT_W'($urandom_range(0, 1200))
                                          : LAT_W'($urandom);
        loss = ($urandom_range(0, 9) < 7) ? LOSS_W'($urandom_range(0, 10000))
                                          : LOSS_W'($urandom);
        jit  = ($urandom_range(0, 9) < 8) ? JIT_W'($urandom_range(0, 250))
                                          : JIT_W'($urandom);
        case ($urandom_range(0, 5))
            0:       thr = '0;
            1:       thr = THR_W'(ref_bps) - 24'd1;
            2:       thr = THR_W'(ref_bps);
            3:       thr = THR_W'(ref_bps) + 24'd1;
            4:       thr = THR_W'($urandom_range(0, 2 * ref_bps));
            default: thr = THR_W'($urandom);
        endcase
        send_item(f, lat, loss, jit, thr);
    endtask

    task automatic test_directed_edges();
        send_tick();
        send_tick();
        send_item(FUNC_THR, 16'hFFFF, 15'h7FFF, 16'hFFFF, 24'd600);
        send_tick();
        // loss estimate bands on both sides of each threshold
        send_item(FUNC_LAT_OBS, 16'd151, 15'h7FFF, 16'hFFFF, 24'hFFFFFF);
        send_item(FUNC_LAT_OBS, 16'd150, '0, '0, '0);
        send_item(FUNC_LAT_OBS, 16'd401, '0, '0, '0);
        send_item(FUNC_LAT_OBS, 16'd400, '0, '0, '0);
        send_item(FUNC_LAT_OBS, 16'd801, '0, '0, '0);
        send_item(FUNC_LAT_OBS, 16'd800, '0, '0, '0);
        send_item(FUNC_LAT_OBS, 16'hFFFF, '0, '0, '0);
        send_tick();
        send_item(FUNC_LAT_OBS, 16'd0, '0, '0, '0);
        send_tick();
        // most negative loss, then largest positive
        send_item(FUNC_DIRECT, 16'hFFFF, 15'h4000, 16'hFFFF, 24'hFFFFFF);
        send_tick();
        send_item(FUNC_DIRECT, 16'd0, 15'h3FFF, 16'd0, '0);
        send_tick();
        send_item(FUNC_DIRECT, 16'd1000, 15'd10000, 16'd200, '0);
        send_item(FUNC_THR, '0, '0, '0, 24'd599);
        send_tick();
        send_tick();
        send_item(FUNC_THR, '0, '0, '0, 24'hFFFFFF);
        send_tick();
        send_item(FUNC_DIRECT, '0, 15'h7FFF, '0, '0);
        send_tick();
    endtask

    task automatic test_zero_settings();
        // zero reference: nonzero throughput scores nothing; zero confirm acts as one
        cfg_write(CFG_REF, '0);
        cfg_write(CFG_CONFIRM, '0);
        send_item(FUNC_THR, '0, '0, '0, 24'd1);
        send_tick();
        send_item(FUNC_THR, '0, '0, '0, '0);
        send_tick();
        send_item(FUNC_DIRECT, 16'd500, 15'd2000, 16'd40, '0);
        send_tick();
        send_item(FUNC_THR, '0, '0, '0, 24'hFFFFFF);
        send_tick();
    endtask

    task automatic test_widest_settings();
        cfg_write(CFG_REF, {REF_W{1'b1}});
        cfg_write(CFG_CONFIRM, 20'd7);
        send_item(FUNC_THR, '0, '0, '0, 24'd1);
        send_item(FUNC_DIRECT, 16'd700, 15'd5000, 16'd120, '0);
        repeat (9) send_tick();
        send_item(FUNC_DIRECT, '0, '0, '0, '0);
        repeat (9) send_tick();
    endtask

    task automatic test_random_traffic();
        int r;
        int sent;
        for (int phase = 0; phase < 7; phase++) begin
            case (phase)
                0: begin
                    cfg_write(CFG_REF, 20'd1);
                    cfg_write(CFG_CONFIRM, 20'd1);
                end
                1: begin
                    cfg_write(CFG_REF, 20'd1000000);
                    cfg_write(CFG_CONFIRM, 20'd7);
                end
                default: begin
                    case ($urandom_range(0, 3))
                        0:       cfg_write(CFG_REF, REF_W'($urandom_range(1, 1000)));
                        1:       cfg_write(CFG_REF, REF_W'($urandom_range(1, 1000000)));
                        2:       cfg_write(CFG_REF, '0);
                        default: cfg_write(CFG_REF, REF_W'($urandom_range(0, 20'hFFFFF)));
                    endcase
                    cfg_write(CFG_CONFIRM, REF_W'($urandom_range(0, 7)));
                end
            endcase
            // one phase runs with no idling on either side
            idle_pct = (phase == 3) ? 0 : 28;
            sent = 0;
            while (sent < 100) begin
                r = $urandom_range(0, 99);
                if (r < 35) begin
                    send_tick();
                    sent++;
                end else if (r < 55) begin
                    send_random_update(FUNC_LAT_OBS);
                    sent++;
                end else if (r < 70) begin
                    send_random_update(FUNC_DIRECT);
                    sent++;
                end else if (r < 85) begin
                    send_random_update(FUNC_THR);
                    sent++;
                end else begin
                    // run of ticks so the stage filter can confirm
                    repeat ($urandom_range(2, 9)) begin
                        send_tick();
                        sent++;
                    end
                end
            end
        end
        idle_pct = 28;
    endtask

    initial begin
        ref_bps      = 20'd600;
        confirm_need = 3'd2;
        lat_now      = '0;
        lat_prev     = '0;
        loss_now     = '0;
        jit_now      = '0;
        thr_now      = '0;
        stress_now   = '0;
        stage_now    = STAGE_1;
        stage_cand   = STAGE_1;
        agree_cnt    = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed_edges();
        test_zero_settings();
        test_widest_settings();
        test_random_traffic();
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
